[rtl/fpcr_pkg.sv]
// shared types, constants and codes for the fft product carry release block
package fpcr_pkg;

  localparam int COEF_W      = 64;
  localparam int DIGIT_W     = 14;
  localparam int QUEUE_DEPTH = 8;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 6;

  // digit bases and their split into a power of two times an odd factor
  localparam logic [DIGIT_W-1:0] BASE_HI = 14'd10000;
  localparam logic [DIGIT_W-1:0] BASE_LO = 14'd100;
  localparam int PSHIFT_HI = 4;
  localparam int PSHIFT_LO = 2;

  // reciprocals of the odd factors 625 and 25, exact for any 63-bit dividend
  localparam int SHIFT_25  = 68;
  localparam int SHIFT_625 = 73;
  localparam logic [63:0] MAGIC_25  = 64'(((128'd1 << SHIFT_25) / 128'd25) + 128'd1);
  localparam logic [63:0] MAGIC_625 = 64'(((128'd1 << SHIFT_625) / 128'd625) + 128'd1);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE_SHIFT = 1'b0,
    CFG_BASE_SELECT = 1'b1
  } cfg_reg_e;

  // carry loop sequencer
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_STEP,
    ST_DONE
  } back_state_e;

  // one classified coefficient waiting for the carry loop
  typedef struct packed {
    logic signed [COEF_W-1:0] quot;
    logic [DIGIT_W-1:0]       rem;
    logic                     base_hi;
    logic                     last;
  } fpcr_item_t;

endpackage

[rtl/fpcr_cdiv.sv]
// two-stage floor divmod of a signed 64-bit value by 10000 or 100
module fpcr_cdiv import fpcr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic signed [COEF_W-1:0] value_i,
  input  logic                     base_hi_i,
  output logic signed [COEF_W-1:0] quot_o,
  output logic [DIGIT_W-1:0]       rem_o
);

  logic signed [COEF_W-1:0] x_s;
  logic [COEF_W-1:0]        y_s;
  logic [63:0]              magic;
  logic [63:0]              pp_hh_d, pp_hl_d, pp_lh_d, pp_ll_d;
  logic [63:0]              pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic                     neg_q, base1_q, base2_q;
  logic [DIGIT_W-1:0]       vlow1_q, vlow2_q;
  logic [64:0]              mid;
  logic [127:0]             sum;
  logic [COEF_W-1:0]        qu;
  logic signed [COEF_W-1:0] quot_d, quot_q;
  logic [DIGIT_W-1:0]       base_v;
  logic [2*DIGIT_W-1:0]     back_prod;

  // strip the power of two, fold negatives onto the non-negative range
  always_comb begin
    x_s = base_hi_i ? (value_i >>> PSHIFT_HI) : (value_i >>> PSHIFT_LO);
    y_s = value_i[COEF_W-1] ? ~x_s : x_s;
    magic = base_hi_i ? MAGIC_625 : MAGIC_25;
    pp_hh_d = 64'(y_s[63:32]) * 64'(magic[63:32]);
    pp_hl_d = 64'(y_s[63:32]) * 64'(magic[31:0]);
    pp_lh_d = 64'(y_s[31:0]) * 64'(magic[63:32]);
    pp_ll_d = 64'(y_s[31:0]) * 64'(magic[31:0]);
  end

  // partial products
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pp_hh_q <= pp_hh_d;
      pp_hl_q <= pp_hl_d;
      pp_lh_q <= pp_lh_d;
      pp_ll_q <= pp_ll_d;
      neg_q   <= value_i[COEF_W-1];
      base1_q <= base_hi_i;
      vlow1_q <= value_i[DIGIT_W-1:0];
    end
  end

  // sum the partial products and keep the quotient bits
  always_comb begin
    mid = 65'(pp_hl_q) + 65'(pp_lh_q);
    sum = {pp_hh_q, pp_ll_q} + (128'(mid) << 32);
    qu = base1_q ? 64'(sum[127:SHIFT_625]) : 64'(sum[127:SHIFT_25]);
    quot_d = neg_q ? ~qu : qu;
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      quot_q  <= quot_d;
      base2_q <= base1_q;
      vlow2_q <= vlow1_q;
    end
  end

  // remainder only needs the low digit bits of value minus quotient times base
  always_comb begin
    base_v = base2_q ? BASE_HI : BASE_LO;
    back_prod = (2*DIGIT_W)'(quot_q[DIGIT_W-1:0]) * (2*DIGIT_W)'(base_v);
  end

  assign quot_o = quot_q;
  assign rem_o  = vlow2_q - back_prod[DIGIT_W-1:0];

endmodule

[rtl/fpcr_fifo.sv]
// small register queue between the classify front and the carry loop
module fpcr_fifo import fpcr_pkg::*; #(
  parameter int WIDTH = 80
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  rdata_o,
  output logic              empty_o,
  output logic [QCNT_W-1:0] count_o
);

  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [WIDTH-1:0]  mem_q [QUEUE_DEPTH];
  logic [AW-1:0]     wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + AW'(1);
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < QCNT_W'(QUEUE_DEPTH))
    else $error("queue written while full");

endmodule

[rtl/fpcr_front.sv]
// input side: config registers, rounding shift and divmod of each coefficient
module fpcr_front import fpcr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [COEF_W-1:0]     in_coef_i,
  input  logic                  in_last_i,
  input  logic [QCNT_W-1:0]     q_count_i,
  output logic                  push_o,
  output fpcr_item_t            item_o
);

  localparam int TW = $clog2(FRAC_BITS + COEF_W + 1);

  logic [CFG_DATA_W-1:0]    scale_q;
  logic                     base_sel_q;
  logic                     accept;
  logic signed [COEF_W-1:0] coef;
  logic [TW-1:0]            tot;
  logic                     big;
  logic [5:0]               tm1;
  logic signed [COEF_W-1:0] shr;
  logic signed [COEF_W-1:0] rnd_d, rnd_q;
  logic                     v0_q, v1_q, v2_q;
  logic                     last0_q, last1_q, last2_q;
  logic                     base0_q, base1_q, base2_q;
  logic [QCNT_W-1:0]        pending;
  logic signed [COEF_W-1:0] div_quot;
  logic [DIGIT_W-1:0]       div_rem;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= '0;
      base_sel_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_SCALE_SHIFT: scale_q    <= cfg_data_i;
        CFG_BASE_SELECT: base_sel_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // room check counts items still in the pipeline as taken slots
  assign pending    = q_count_i + QCNT_W'(v0_q) + QCNT_W'(v1_q) + QCNT_W'(v2_q);
  assign in_ready_o = pending < QCNT_W'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  // normalize and round to nearest, ties up
  always_comb begin
    coef  = $signed(in_coef_i);
    tot   = TW'(FRAC_BITS) + TW'(scale_q);
    big   = tot >= TW'(COEF_W);
    tm1   = 6'(tot - TW'(1));
    shr   = coef >>> tot[5:0];
    rnd_d = big ? '0 : shr + 64'(coef[tm1]);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rnd_q   <= rnd_d;
      last0_q <= in_last_i;
      base0_q <= base_sel_q;
    end
    last1_q <= last0_q;
    base1_q <= base0_q;
    last2_q <= last1_q;
    base2_q <= base1_q;
  end

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= accept;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  fpcr_cdiv u_div (
    .clk_i     (clk_i),
    .load_i    (v0_q),
    .step_i    (v1_q),
    .value_i   (rnd_q),
    .base_hi_i (base0_q),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  assign push_o          = v2_q;
  assign item_o.quot     = div_quot;
  assign item_o.rem      = div_rem;
  assign item_o.base_hi  = base2_q;
  assign item_o.last     = last2_q;

  a_room_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending <= QCNT_W'(QUEUE_DEPTH))
    else $error("more items in flight than queue slots");

endmodule

[rtl/fpcr_back.sv]
// carry loop: divides the running carry, forms the digit and holds the result
module fpcr_back import fpcr_pkg::*; #(
  parameter int CARRY_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  fpcr_item_t         q_item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [DIGIT_W-1:0] out_digit_o,
  output logic               out_last_o,
  output logic               out_err_o
);

  back_state_e state_q, state_d;

  fpcr_item_t                    item_q;
  logic signed [CARRY_WIDTH-1:0] carry_q;
  logic                          ovf_q;
  logic                          div_step;
  logic                          commit;
  logic signed [COEF_W-1:0]      div_quot;
  logic [DIGIT_W-1:0]            div_rem;
  logic [DIGIT_W-1:0]            base_v;
  logic [DIGIT_W:0]              rsum;
  logic                          bump;
  logic [DIGIT_W-1:0]            digit_d, digit_q;
  logic signed [COEF_W-1:0]      carry_full;
  logic signed [COEF_W-1:0]      carry_hi;
  logic signed [CARRY_WIDTH-1:0] wrapped;
  logic                          ovf_now;
  logic                          err_d, err_q;
  logic                          out_valid_q, last_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (!q_empty_i) state_d = ST_STEP;
      ST_STEP: state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o    = 1'b0;
    div_step = 1'b0;
    commit   = 1'b0;
    unique case (state_q)
      ST_LOAD: pop_o    = !q_empty_i;
      ST_STEP: div_step = 1'b1;
      ST_DONE: commit   = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= q_item_i;
    end
  end

  fpcr_cdiv u_div (
    .clk_i     (clk_i),
    .load_i    (pop_o),
    .step_i    (div_step),
    .value_i   (64'(carry_q)),
    .base_hi_i (q_item_i.base_hi),
    .quot_o    (div_quot),
    .rem_o     (div_rem)
  );

  // add the two divmod halves, fold the remainder overflow into the carry
  always_comb begin
    base_v     = item_q.base_hi ? BASE_HI : BASE_LO;
    rsum       = (DIGIT_W+1)'(item_q.rem) + (DIGIT_W+1)'(div_rem);
    bump       = rsum >= (DIGIT_W+1)'(base_v);
    digit_d    = bump ? DIGIT_W'(rsum - (DIGIT_W+1)'(base_v)) : DIGIT_W'(rsum);
    carry_full = item_q.quot + div_quot + 64'(bump);
    wrapped    = carry_full[CARRY_WIDTH-1:0];
    carry_hi   = carry_full >>> (CARRY_WIDTH - 1);
    ovf_now    = (carry_hi != '0) && (carry_hi != '1);
    err_d      = item_q.last && ((wrapped != '0) || ovf_q || ovf_now);
  end

  // running carry, cleared at the end of each product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
      ovf_q   <= 1'b0;
    end else if (commit) begin
      carry_q <= item_q.last ? '0 : wrapped;
      ovf_q   <= item_q.last ? 1'b0 : (ovf_q || ovf_now);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      digit_q <= digit_d;
      last_q  <= item_q.last;
      err_q   <= err_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_digit_o = digit_q;
  assign out_last_o  = last_q;
  assign out_err_o   = err_q;

  a_carry_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit && item_q.last |=> carry_q == '0 && !ovf_q)
    else $error("carry not cleared after final coefficient");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> digit_q < BASE_HI)
    else $error("digit out of range");

  a_err_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !last_q |-> !err_q)
    else $error("error flag on a digit that is not the final one");

endmodule

[rtl/fft_product_carry_release.sv]
// top level of the fft product carry release block
//
//  channel   direction  transfer condition               contents
//  s_axis    in         s_axis_tvalid & s_axis_tready   coefficient, last_coefficient
//  m_axis    out        m_axis_tvalid & m_axis_tready   digit, carry_error, last_digit
//  cfg       in         cfg_we_i                        scale_shift (0), base_select (1)
//
// the carry loop (carry -> reciprocal multiply -> quotient -> carry add) runs through the load,
// step and done states per digit and pops the next coefficient only once the digit is committed
// from an idle block a coefficient passes the front stages, the queue write, then the carry loop states
// the input takes one coefficient per cycle until 8 sit in the 3 front stages and the queue
// a stalled output holds the carry loop only; the front keeps filling the queue
// reset needs no clearing pass; the carry and its overflow flag clear at once
module fft_product_carry_release import fpcr_pkg::*; #(
  parameter int FRAC_BITS   = 16,
  parameter int CARRY_WIDTH = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [63:0] coefficient
  input  logic [COEF_W-1:0]     s_axis_tdata,
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [13:0] digit, [14] carry_error, [15] zero
  output logic [15:0]           m_axis_tdata,
  output logic                  m_axis_tlast
);

  logic               push;
  fpcr_item_t         push_item;
  logic               pop;
  fpcr_item_t         head_item;
  logic               q_empty;
  logic [QCNT_W-1:0]  q_count;
  logic [DIGIT_W-1:0] digit;
  logic               carry_err;

  fpcr_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_coef_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_count_i  (q_count),
    .push_o     (push),
    .item_o     (push_item)
  );

  fpcr_fifo #(
    .WIDTH ($bits(fpcr_item_t))
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_item),
    .pop_i   (pop),
    .rdata_o (head_item),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  fpcr_back #(
    .CARRY_WIDTH (CARRY_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_digit_o (digit),
    .out_last_o  (m_axis_tlast),
    .out_err_o   (carry_err)
  );

  assign m_axis_tdata = {1'b0, carry_err, digit};

endmodule
